// ----- design/oale_pkg.sv -----
package oale_pkg;

	localparam int DEFAULT_LIST_DEPTH = 64;

	// match flags examined per scan cycle during find
	localparam int SCAN_W = 32;
	localparam int SCAN_IDX_W = $clog2(SCAN_W);

	localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [2:0] REQ_POP_BACK   = 3'd1;
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd2;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [2:0] REQ_INSERT     = 3'd4;
	localparam logic [2:0] REQ_ERASE      = 3'd5;
	localparam logic [2:0] REQ_FIND       = 3'd6;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BADPOS   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [6:0]         position;
		logic signed [31:0] value;
	} req_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] found_index;
		logic [6:0] count;
	} rsp_item_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_OPEN,
		CELL_CLOSE,
		CELL_CMP
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [31:0] value;
	} cell_cmd_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} oale_state_t;

endpackage

// ----- design/oale_cell.sv -----
module oale_cell #(
	parameter int INDEX = 0,
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  logic                clk,
	input  oale_pkg::cell_cmd_t cmd,
	input  logic [IDX_W-1:0]    pos,
	input  logic [CNT_W-1:0]    count,
	input  logic [31:0]         left_data,
	input  logic [31:0]         right_data,
	output logic [31:0]         data,
	output logic                match
);

	localparam logic [CNT_W:0] MY_IDX  = (CNT_W+1)'(INDEX);
	localparam logic [CNT_W:0] NEXT_IDX = (CNT_W+1)'(INDEX + 1);

	logic [31:0]    data_q;
	logic           match_q;
	logic [CNT_W:0] pos_ext;
	logic [CNT_W:0] cnt_ext;

	assign pos_ext = (CNT_W+1)'(pos);
	assign cnt_ext = (CNT_W+1)'(count);

	always_ff @(posedge clk) begin
		case (cmd.op)
			oale_pkg::CELL_OPEN: begin
				if (MY_IDX == pos_ext) begin
					data_q <= cmd.value;
				end else if (MY_IDX > pos_ext && MY_IDX <= cnt_ext) begin
					data_q <= left_data;
				end
			end
			oale_pkg::CELL_CLOSE: begin
				if (MY_IDX >= pos_ext && NEXT_IDX < cnt_ext) begin
					data_q <= right_data;
				end
			end
			oale_pkg::CELL_CMP: begin
				match_q <= (data_q == cmd.value) && (MY_IDX < cnt_ext);
			end
			default: begin
			end
		endcase
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

// ----- design/ordered_array_list_engine_unit.sv -----
// ordered list engine: holds up to LIST_DEPTH 32-bit words in a row of cells
// requests arrive on req (req_valid/req_ready), one rsp item returns per request
// on rsp (rsp_valid/rsp_ready) carrying status, found index and the new count
// push, pop, insert and erase: every cell that moves does so in the same
// cycle, taking its left or right neighbor's word, so the item is done in
// the accept cycle and its response is valid on the next cycle; one such
// item per cycle while the response register is free
// find: the cells compare in the accept cycle, then the match flags are scanned
// 32 per cycle from index 0 up, stopping at the first hit; no new item is taken
// while the scan runs
// the response sits in an output register; a new item is taken while it
// waits only if it is taken out in the same cycle, so a stalled receiver
// stalls req_ready after one response
// reset clears the count and the control state; words in the cells are not
// cleared and are never read before being written
// count is reported in 7 bits and found index in 6 bits
module ordered_array_list_engine_unit #(
	parameter int LIST_DEPTH = oale_pkg::DEFAULT_LIST_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  oale_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output oale_pkg::rsp_item_t rsp
);

	localparam int IW  = $clog2(LIST_DEPTH);
	localparam int CW  = $clog2(LIST_DEPTH + 1);
	localparam int PW  = (CW > 7) ? CW : 7;
	localparam int NG  = (LIST_DEPTH + oale_pkg::SCAN_W - 1) / oale_pkg::SCAN_W;
	localparam int GBW = (NG > 1) ? $clog2(NG) : 1;
	localparam int MW  = NG * oale_pkg::SCAN_W;
	localparam int FW  = GBW + oale_pkg::SCAN_IDX_W;

	oale_pkg::oale_state_t state_q, state_d;
	logic [CW-1:0]  count_q, cnt_d;
	logic [GBW-1:0] grp_q;
	oale_pkg::rsp_item_t rsp_q;
	logic           rsp_valid_q;

	oale_pkg::cell_op_t  op;
	oale_pkg::cell_cmd_t cmd;
	logic [IW-1:0]  cell_pos;
	logic [2:0]     status;
	logic           is_find;
	logic           accept;
	logic           out_free;
	logic           scan_load;
	logic           full, empty;
	logic [PW-1:0]  pos_ext, cnt_ext;

	logic [31:0]    data_w [LIST_DEPTH];
	logic [MW-1:0]  match_vec;
	logic [oale_pkg::SCAN_W-1:0]     slice;
	logic [oale_pkg::SCAN_IDX_W-1:0] enc;
	logic           hit;
	logic           last_grp;
	logic           scan_end;
	logic [FW-1:0]  fidx;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign accept   = req_valid && req_ready;
	assign full     = count_q == CW'(LIST_DEPTH);
	assign empty    = count_q == '0;
	assign pos_ext  = PW'(req.position);
	assign cnt_ext  = PW'(count_q);

	always_comb begin
		op       = oale_pkg::CELL_HOLD;
		cell_pos = '0;
		status   = oale_pkg::ST_OK;
		cnt_d    = count_q;
		is_find  = 1'b0;
		case (req.req_type)
			oale_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					status = oale_pkg::ST_FULL;
				end else begin
					op       = oale_pkg::CELL_OPEN;
					cell_pos = IW'(count_q);
					cnt_d    = count_q + 1'b1;
				end
			end
			oale_pkg::REQ_POP_BACK: begin
				if (empty) begin
					status = oale_pkg::ST_EMPTY;
				end else begin
					cnt_d = count_q - 1'b1;
				end
			end
			oale_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					status = oale_pkg::ST_FULL;
				end else begin
					op    = oale_pkg::CELL_OPEN;
					cnt_d = count_q + 1'b1;
				end
			end
			oale_pkg::REQ_POP_FRONT: begin
				if (empty) begin
					status = oale_pkg::ST_EMPTY;
				end else begin
					op    = oale_pkg::CELL_CLOSE;
					cnt_d = count_q - 1'b1;
				end
			end
			oale_pkg::REQ_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status = oale_pkg::ST_BADPOS;
				end else if (full) begin
					status = oale_pkg::ST_FULL;
				end else begin
					op       = oale_pkg::CELL_OPEN;
					cell_pos = IW'(req.position);
					cnt_d    = count_q + 1'b1;
				end
			end
			oale_pkg::REQ_ERASE: begin
				if (empty) begin
					status = oale_pkg::ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					status = oale_pkg::ST_BADPOS;
				end else begin
					op       = oale_pkg::CELL_CLOSE;
					cell_pos = IW'(req.position);
					cnt_d    = count_q - 1'b1;
				end
			end
			oale_pkg::REQ_FIND: begin
				op      = oale_pkg::CELL_CMP;
				is_find = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign cmd.op    = accept ? op : oale_pkg::CELL_HOLD;
	assign cmd.value = req.value;

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic [31:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = data_w[i-1];
		end
		if (i == LIST_DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = data_w[i+1];
		end
		oale_cell #(
			.INDEX(i),
			.IDX_W(IW),
			.CNT_W(CW)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.pos       (cell_pos),
			.count     (count_q),
			.left_data (left_w),
			.right_data(right_w),
			.data      (data_w[i]),
			.match     (match_vec[i])
		);
	end

	if (MW > LIST_DEPTH) begin : g_pad
		assign match_vec[MW-1:LIST_DEPTH] = '0;
	end

	// lowest set flag in the current group of 32
	assign slice = match_vec[grp_q*oale_pkg::SCAN_W +: oale_pkg::SCAN_W];
	assign hit   = |slice;

	always_comb begin
		enc = '0;
		for (int k = oale_pkg::SCAN_W - 1; k >= 0; k--) begin
			if (slice[k]) begin
				enc = oale_pkg::SCAN_IDX_W'(k);
			end
		end
	end

	assign last_grp = grp_q == GBW'(NG - 1);
	assign scan_end = hit || last_grp;
	assign fidx     = {grp_q, enc};

	always_comb begin
		state_d = state_q;
		case (state_q)
			oale_pkg::S_IDLE: begin
				if (accept && is_find) begin
					state_d = oale_pkg::S_SCAN;
				end
			end
			oale_pkg::S_SCAN: begin
				if (scan_end && out_free) begin
					state_d = oale_pkg::S_IDLE;
				end
			end
			default: state_d = oale_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		scan_load = 1'b0;
		case (state_q)
			oale_pkg::S_IDLE: req_ready = out_free;
			oale_pkg::S_SCAN: scan_load = scan_end && out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= oale_pkg::S_IDLE;
			count_q     <= '0;
			grp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= cnt_d;
			end
			if (accept && is_find) begin
				grp_q <= '0;
			end else if (state_q == oale_pkg::S_SCAN && !scan_end) begin
				grp_q <= grp_q + 1'b1;
			end
			if ((accept && !is_find) || scan_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_find) begin
			rsp_q.status      <= status;
			rsp_q.found_index <= '0;
			rsp_q.count       <= 7'(cnt_d);
		end else if (scan_load) begin
			rsp_q.status      <= hit ? oale_pkg::ST_OK : oale_pkg::ST_NOTFOUND;
			rsp_q.found_index <= hit ? 6'(fidx) : 6'd0;
			rsp_q.count       <= 7'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(LIST_DEPTH))
		else $error("count above list depth");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count changed without an accepted item");

	a_fast_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_find |=> rsp_valid_q)
		else $error("no response after list update");

	a_find_idx: assert property (@(posedge clk) disable iff (!arst_n)
		scan_load && hit |-> (CW+FW)'(fidx) < (CW+FW)'(count_q))
		else $error("find hit beyond count");

endmodule
